// ===== hw/rtl/smx_pkg.sv =====
package smx_pkg;

    // Default sizes of the stack
    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    // Fixed field widths of the ports
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int VALUE_W  = 32;

    // Opcodes
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_ADD     = 3'd1,
        OP_SUB     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIV     = 3'd4,
        OP_OUT     = 3'd5,
        OP_HLT     = 3'd6,
        OP_INVALID = 3'd7
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_OUTPUT  = 3'd1,
        ST_HALTED  = 3'd2,
        ST_BADOP   = 3'd3,
        ST_UNDER   = 3'd4,
        ST_OVER    = 3'd5,
        ST_DIVZERO = 3'd6,
        ST_IGNORED = 3'd7
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CALC,
        S_WB
    } t_state;

    // Request to the iterative multiply / divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

endpackage

// ===== hw/rtl/smx_stack_ram.sv =====
module smx_stack_ram #(
    parameter int DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = smx_pkg::DATA_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr0,
    input  logic [AW-1:0]    i_rd_addr1,
    output logic [WIDTH-1:0] o_rd_data0,
    output logic [WIDTH-1:0] o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data0 <= r_mem[i_rd_addr0];
            o_rd_data1 <= r_mem[i_rd_addr1];
        end
    end

endmodule

// ===== hw/rtl/smx_muldiv.sv =====
module smx_muldiv #(
    parameter int DATA_WIDTH = smx_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smx_pkg::t_md_req      i_req,
    input  logic [DATA_WIDTH-1:0] i_lhs,
    input  logic [DATA_WIDTH-1:0] i_rhs,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  r_busy;
    logic                  r_div;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_a;    // multiplicand, or dividend shifting into quotient
    logic [DATA_WIDTH-1:0] r_b;    // multiplier bits, or divisor magnitude
    logic [DATA_WIDTH-1:0] r_acc;  // product, or partial remainder

    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fit;

    function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] v);
        mag = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // Restoring division step: shift in next dividend bit, try subtract
    assign w_trial = {r_acc, r_a[DATA_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_b};
    assign w_fit   = (w_trial >= {1'b0, r_b});

    // Control: counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_neg <= i_lhs[DATA_WIDTH-1] ^ i_rhs[DATA_WIDTH-1];
            r_acc <= '0;
            if (i_req.is_div) begin
                r_a <= mag(i_lhs);
                r_b <= mag(i_rhs);
            end else begin
                r_a <= i_lhs;
                r_b <= i_rhs;
            end
        end else if (r_busy) begin
            if (r_div) begin
                r_acc <= w_fit ? w_diff[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
                r_a   <= {r_a[DATA_WIDTH-2:0], w_fit};
            end else begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a << 1;
                r_b <= r_b >> 1;
            end
        end
    end

    // Quotient sign fix-up; product is taken as is
    assign o_result = r_div ? (r_neg ? (~r_a + 1'b1) : r_a) : r_acc;

endmodule

// ===== hw/rtl/stack_machine_executor_top.sv =====
// Stack-machine executor: each input beat carries one instruction (push, add,
// sub, mul, div, out, hlt) and yields exactly one result beat with a status
// and a value. The stack lives in a RAM with two registered read ports: an
// instruction is taken in S_IDLE while the two top entries are read, and is
// executed and written back in S_EXEC once the output register is free. mul
// and div run through a shared bit-serial unit (shift-add, restoring
// division), one bit per cycle, and write back in S_WB. A result waiting in
// the output register does not hold off the next instruction; a second
// result does wait for it to be taken. After hlt or a bad opcode every beat
// returns "ignored" until reset. Stack contents need no clearing after
// reset: only entries below the stack pointer are used.
module stack_machine_executor_top #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = smx_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [smx_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [smx_pkg::VALUE_W-1:0]  i_immediate,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [smx_pkg::STATUS_W-1:0]        o_status,
    output logic signed [smx_pkg::VALUE_W-1:0]  o_value
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    smx_pkg::t_state r_state, n_state;

    logic [SPW-1:0]        r_sp, n_sp;
    logic                  r_halted, n_halted;
    logic [smx_pkg::FUNC_W-1:0] r_func;
    logic [DATA_WIDTH-1:0] r_imm;

    logic                  r_out_valid;
    smx_pkg::t_status      r_status, n_status;
    logic [smx_pkg::VALUE_W-1:0] r_value, n_value;
    logic                  w_out_load;
    logic                  w_out_free;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [DATA_WIDTH-1:0] w_top;
    logic [DATA_WIDTH-1:0] w_second;
    logic [SPW-1:0]        w_sp_m1;
    logic [SPW-1:0]        w_sp_m2;
    logic                  w_accept;

    smx_pkg::t_md_req      w_md_req;
    logic                  w_md_done;
    logic [DATA_WIDTH-1:0] w_md_result;
    logic                  w_use_md;
    logic                  w_have2;
    logic                  w_have1;
    logic                  w_full;
    logic signed [63:0]    w_imm_ext;
    logic signed [63:0]    w_top_ext;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_sp_m1    = r_sp - 1'b1;
    assign w_sp_m2    = r_sp - SPW'(2);
    assign w_have2    = (r_sp >= SPW'(2));
    assign w_have1    = (r_sp != '0);
    assign w_full     = (r_sp >= SPW'(STACK_DEPTH));
    assign w_imm_ext  = 64'(i_immediate);
    assign w_top_ext  = 64'(signed'(w_top));

    // mul or div with valid operands goes to the bit-serial unit
    assign w_use_md = !r_halted && w_have2 &&
                      ((smx_pkg::t_op'(r_func) == smx_pkg::OP_MUL) ||
                       ((smx_pkg::t_op'(r_func) == smx_pkg::OP_DIV) && (w_top != '0)));

    // Stack storage: top two entries read while an instruction is taken
    smx_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_en    (r_state == smx_pkg::S_IDLE),
        .i_rd_addr0 (w_sp_m1[AW-1:0]),
        .i_rd_addr1 (w_sp_m2[AW-1:0]),
        .o_rd_data0 (w_top),
        .o_rd_data1 (w_second)
    );

    smx_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_md_req),
        .i_lhs    (w_second),
        .i_rhs    (w_top),
        .o_done   (w_md_done),
        .o_result (w_md_result)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smx_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = smx_pkg::S_EXEC;
                end
            end
            smx_pkg::S_EXEC: begin
                if (w_use_md) begin
                    n_state = smx_pkg::S_CALC;
                end else if (w_out_free) begin
                    n_state = smx_pkg::S_IDLE;
                end
            end
            smx_pkg::S_CALC: begin
                if (w_md_done) begin
                    n_state = smx_pkg::S_WB;
                end
            end
            smx_pkg::S_WB: begin
                if (w_out_free) begin
                    n_state = smx_pkg::S_IDLE;
                end
            end
            default: n_state = smx_pkg::S_IDLE;
        endcase
    end

    // Execute: stack update, write-back and result
    always_comb begin
        n_sp       = r_sp;
        n_halted   = r_halted;
        n_status   = smx_pkg::ST_OK;
        n_value    = '0;
        w_out_load = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_sp[AW-1:0];
        w_wr_data  = r_imm;
        w_md_req   = '0;
        unique case (r_state)
            smx_pkg::S_EXEC: begin
                if (w_use_md) begin
                    w_md_req.start  = 1'b1;
                    w_md_req.is_div = (smx_pkg::t_op'(r_func) == smx_pkg::OP_DIV);
                end else if (w_out_free) begin
                    w_out_load = 1'b1;
                    if (r_halted) begin
                        n_status = smx_pkg::ST_IGNORED;
                    end else begin
                        unique case (smx_pkg::t_op'(r_func))
                            smx_pkg::OP_PUSH: begin
                                if (w_full) begin
                                    n_status = smx_pkg::ST_OVER;
                                end else begin
                                    w_wr_en = 1'b1;
                                    n_sp    = r_sp + 1'b1;
                                end
                            end
                            smx_pkg::OP_ADD, smx_pkg::OP_SUB: begin
                                if (!w_have2) begin
                                    n_status = smx_pkg::ST_UNDER;
                                end else begin
                                    w_wr_en   = 1'b1;
                                    w_wr_addr = w_sp_m2[AW-1:0];
                                    w_wr_data = (smx_pkg::t_op'(r_func) == smx_pkg::OP_ADD) ?
                                                (w_second + w_top) : (w_second - w_top);
                                    n_sp      = w_sp_m1;
                                end
                            end
                            smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
                                // only failures reach here; good operands go to the unit
                                n_status = w_have2 ? smx_pkg::ST_DIVZERO : smx_pkg::ST_UNDER;
                            end
                            smx_pkg::OP_OUT: begin
                                if (!w_have1) begin
                                    n_status = smx_pkg::ST_UNDER;
                                end else begin
                                    n_sp     = w_sp_m1;
                                    n_status = smx_pkg::ST_OUTPUT;
                                    n_value  = w_top_ext[smx_pkg::VALUE_W-1:0];
                                end
                            end
                            smx_pkg::OP_HLT: begin
                                n_halted = 1'b1;
                                n_status = smx_pkg::ST_HALTED;
                            end
                            smx_pkg::OP_INVALID: begin
                                n_halted = 1'b1;
                                n_status = smx_pkg::ST_BADOP;
                            end
                            default: n_status = smx_pkg::ST_BADOP;
                        endcase
                    end
                end
            end
            smx_pkg::S_WB: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_wr_en    = 1'b1;
                    w_wr_addr  = w_sp_m2[AW-1:0];
                    w_wr_data  = w_md_result;
                    n_sp       = w_sp_m1;
                end
            end
            smx_pkg::S_IDLE, smx_pkg::S_CALC: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smx_pkg::S_IDLE;
            r_sp     <= '0;
            r_halted <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_halted <= n_halted;
        end
    end

    // Instruction capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_imm  <= w_imm_ext[DATA_WIDTH-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    assign o_stall  = (r_state != smx_pkg::S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_value  = r_value;

endmodule

// ===== sim/tb_stack_machine_executor_top.sv =====
module tb_stack_machine_executor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH     = smx_pkg::STACK_DEPTH_DEF;
    localparam int RAND_ITEMS      = 1700;
    localparam int QUIET_ITEMS     = 200;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 2 * (smx_pkg::DATA_WIDTH_DEF + 4) + 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;

    // Random program shaping: free mix, fill to overflow, drain to underflow
    typedef enum {
        MODE_MIX,
        MODE_FILL,
        MODE_DRAIN
    } t_gen_mode;

    typedef struct {
        smx_pkg::t_status            status;
        logic [smx_pkg::VALUE_W-1:0] value;
    } t_exec_result;

    // Tracks the machine state and the results still owed by the block
    class stack_result_tracker;
        logic [smx_pkg::VALUE_W-1:0] stack_mem [STACK_DEPTH];
        int unsigned                 sp;
        bit                          halted;
        t_exec_result                owed_results [$];
        int                          mismatches;
        int                          results_checked;
        int                          status_seen [8];

        function new();
            sp = 0;
            halted = 1'b0;
            mismatches = 0;
            results_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int depth();
            return sp;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Execute one accepted instruction and queue its result
        function void note_instr(smx_pkg::t_op op, logic [smx_pkg::VALUE_W-1:0] imm);
            t_exec_result                r;
            logic [smx_pkg::VALUE_W-1:0] lhs;
            logic [smx_pkg::VALUE_W-1:0] rhs;
            logic [smx_pkg::VALUE_W-1:0] mag_l;
            logic [smx_pkg::VALUE_W-1:0] mag_r;
            logic [smx_pkg::VALUE_W-1:0] q;
            r.status = smx_pkg::ST_OK;
            r.value  = '0;
            q        = '0;
            if (halted) begin
                r.status = smx_pkg::ST_IGNORED;
            end else begin
                case (op)
                    smx_pkg::OP_PUSH: begin
                        if (sp >= STACK_DEPTH) begin
                            r.status = smx_pkg::ST_OVER;
                        end else begin
                            stack_mem[sp] = imm;
                            sp++;
                        end
                    end
                    smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
                        if (sp < 2) begin
                            r.status = smx_pkg::ST_UNDER;
                        end else begin
                            rhs = stack_mem[sp-1];
                            lhs = stack_mem[sp-2];
                            if (op == smx_pkg::OP_DIV && rhs == '0) begin
                                r.status = smx_pkg::ST_DIVZERO;
                            end else begin
                                case (op)
                                    smx_pkg::OP_ADD: q = lhs + rhs;
                                    smx_pkg::OP_SUB: q = lhs - rhs;
                                    smx_pkg::OP_MUL: q = lhs * rhs;
                                    default: begin
                                        // truncate toward zero via magnitudes
                                        mag_l = lhs[smx_pkg::VALUE_W-1] ? -lhs : lhs;
                                        mag_r = rhs[smx_pkg::VALUE_W-1] ? -rhs : rhs;
                                        q = mag_l / mag_r;
                                        if (lhs[smx_pkg::VALUE_W-1] ^ rhs[smx_pkg::VALUE_W-1])
                                            q = -q;
                                    end
                                endcase
                                stack_mem[sp-2] = q;
                                sp--;
                            end
                        end
                    end
                    smx_pkg::OP_OUT: begin
                        if (sp < 1) begin
                            r.status = smx_pkg::ST_UNDER;
                        end else begin
                            sp--;
                            r.value  = stack_mem[sp];
                            r.status = smx_pkg::ST_OUTPUT;
                        end
                    end
                    smx_pkg::OP_HLT: begin
                        halted   = 1'b1;
                        r.status = smx_pkg::ST_HALTED;
                    end
                    default: begin
                        halted   = 1'b1;
                        r.status = smx_pkg::ST_BADOP;
                    end
                endcase
            end
            status_seen[r.status]++;
            owed_results.push_back(r);
        endfunction

        // Compare one result beat against the oldest owed result
        function void check_result(logic [smx_pkg::STATUS_W-1:0] status,
                                   logic [smx_pkg::VALUE_W-1:0] value);
            t_exec_result want;
            results_checked++;
            if (owed_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result beat: status %0d value %h", status, value);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                if (want.status !== status || want.value !== value) begin
                    if (mismatches < MAX_REPORTS)
                        $display("result %0d: expected status %0d value %h, %s %0d value %h",
                                 results_checked, want.status, want.value, "got status",
                                 status, value);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [smx_pkg::FUNC_W-1:0]          i_func;
    logic signed [smx_pkg::VALUE_W-1:0]  i_immediate;
    logic                                o_valid;
    logic                                i_stall;
    logic [smx_pkg::STATUS_W-1:0]        o_status;
    logic signed [smx_pkg::VALUE_W-1:0]  o_value;

    stack_result_tracker sb;
    int                  sent_count = 0;
    int                  cycle_count = 0;
    bit                  quiet = 1'b0;
    bit                  pressure_done = 1'b0;
    t_gen_mode           mode = MODE_MIX;
    int                  extra_left = 0;

    stack_machine_executor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_immediate (i_immediate),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value     (o_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle bursts off in every third stretch of 150 beats and in the tail
    function automatic bit idling_allowed();
        return !quiet && ((sent_count / 150) % 3 != 2);
    endfunction

    // Operand mix: full range, small values near zero, and the extremes
    function automatic logic [smx_pkg::VALUE_W-1:0] rand_word();
        logic [smx_pkg::VALUE_W-1:0] w;
        case ($urandom_range(0, 5))
            1: w = $urandom_range(0, 8) - 4;
            2: begin
                case ($urandom_range(0, 4))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7fff_ffff;
                    2: w = 32'hffff_ffff;
                    3: w = 32'h0000_0001;
                    default: w = 32'h0000_0000;
                endcase
            end
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // Offer one instruction beat and hold it until accepted
    task automatic send_instr(input smx_pkg::t_op op,
                              input logic [smx_pkg::VALUE_W-1:0] imm);
        int gap;
        if (idling_allowed() && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= op;
        i_immediate <= imm;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_instr(op, imm);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Pick the next random instruction from the current stack depth
    task automatic pick_instr(output smx_pkg::t_op op,
                              output logic [smx_pkg::VALUE_W-1:0] imm);
        int d;
        int roll;
        d   = sb.depth();
        imm = $urandom();
        op  = smx_pkg::OP_PUSH;
        case (mode)
            MODE_FILL: begin
                imm = rand_word();
                if (d >= STACK_DEPTH) begin
                    extra_left--;
                    if (extra_left <= 0) begin
                        mode = MODE_DRAIN;
                        extra_left = $urandom_range(1, 3);
                    end
                end
            end
            MODE_DRAIN: begin
                op = smx_pkg::t_op'($urandom_range(smx_pkg::OP_ADD, smx_pkg::OP_OUT));
                if (d == 0) begin
                    extra_left--;
                    if (extra_left <= 0) mode = MODE_MIX;
                end
            end
            default: begin
                roll = $urandom_range(0, 399);
                if (roll < 1) begin
                    mode = MODE_FILL;
                    extra_left = $urandom_range(1, 3);
                    imm = rand_word();
                end else if (roll < 30) begin
                    // noise: any executing opcode regardless of depth
                    op = smx_pkg::t_op'($urandom_range(smx_pkg::OP_PUSH, smx_pkg::OP_OUT));
                    if (op == smx_pkg::OP_PUSH) imm = rand_word();
                end else if (d < 2) begin
                    if ($urandom_range(0, 4) == 0) op = smx_pkg::OP_OUT;
                    else imm = rand_word();
                end else begin
                    roll = $urandom_range(0, 19);
                    if (roll < 7) imm = rand_word();
                    else if (roll < 10) op = smx_pkg::OP_OUT;
                    else op = smx_pkg::t_op'($urandom_range(smx_pkg::OP_ADD, smx_pkg::OP_DIV));
                end
            end
        endcase
    endtask

    // Corner cases: empty stack, wrap, min over minus one, zero divisor
    task automatic run_directed();
        send_instr(smx_pkg::OP_OUT, $urandom());
        send_instr(smx_pkg::OP_ADD, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'h7fff_ffff);
        send_instr(smx_pkg::OP_DIV, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0001);
        send_instr(smx_pkg::OP_ADD, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'hffff_ffff);
        send_instr(smx_pkg::OP_DIV, $urandom());
        send_instr(smx_pkg::OP_OUT, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0000);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0000);
        send_instr(smx_pkg::OP_DIV, $urandom());
        send_instr(smx_pkg::OP_SUB, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'hffff_fff9);
        send_instr(smx_pkg::OP_PUSH, 32'h0000_0002);
        send_instr(smx_pkg::OP_DIV, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'h7fff_ffff);
        send_instr(smx_pkg::OP_MUL, $urandom());
        send_instr(smx_pkg::OP_PUSH, 32'h8000_0000);
        send_instr(smx_pkg::OP_SUB, $urandom());
        send_instr(smx_pkg::OP_OUT, $urandom());
        send_instr(smx_pkg::OP_OUT, $urandom());
        send_instr(smx_pkg::OP_OUT, $urandom());
    endtask

    // Result side: random stall bursts plus one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && sent_count >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_CYCLES;
            end else if (hold_left == 0 && idling_allowed() && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(1, 4);
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_status, o_value);
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count, sb.pending());
        $display("tb_stack_machine_executor_top NOT OK");
        $finish;
    end

    initial begin
        smx_pkg::t_op                op;
        smx_pkg::t_op                term_op;
        smx_pkg::t_op                next_op;
        logic [smx_pkg::VALUE_W-1:0] imm;
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_func      = smx_pkg::OP_PUSH;
        i_immediate = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Random programs, starting with a fill to overflow
        mode = MODE_FILL;
        extra_left = $urandom_range(1, 3);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n >= RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            pick_instr(op, imm);
            send_instr(op, imm);
        end

        // Stop the machine; everything after it is ignored
        if ($urandom_range(0, 1) != 0) begin
            term_op = smx_pkg::OP_HLT;
            next_op = smx_pkg::OP_INVALID;
        end else begin
            term_op = smx_pkg::OP_INVALID;
            next_op = smx_pkg::OP_HLT;
        end
        send_instr(term_op, $urandom());
        send_instr(next_op, $urandom());
        for (int n = 0; n < 8; n++) begin
            send_instr(smx_pkg::t_op'($urandom_range(smx_pkg::OP_PUSH, smx_pkg::OP_INVALID)),
                       $urandom());
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d instruction beats and %0d result beats in %0d cycles",
                 sent_count, sb.results_checked, cycle_count);
        $display("statuses: ok %0d out %0d hlt %0d badop %0d under %0d over %0d div0 %0d ign %0d",
                 sb.status_seen[smx_pkg::ST_OK], sb.status_seen[smx_pkg::ST_OUTPUT],
                 sb.status_seen[smx_pkg::ST_HALTED], sb.status_seen[smx_pkg::ST_BADOP],
                 sb.status_seen[smx_pkg::ST_UNDER], sb.status_seen[smx_pkg::ST_OVER],
                 sb.status_seen[smx_pkg::ST_DIVZERO], sb.status_seen[smx_pkg::ST_IGNORED]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_stack_machine_executor_top OK");
        end else begin
            $display("%0d mismatches, %0d results owed", sb.mismatches, sb.pending());
            $display("tb_stack_machine_executor_top NOT OK");
        end
        $finish;
    end

endmodule
